// File: hdl/dadmd_pkg.sv
package dadmd_pkg;

   localparam int SampleWidth   = 12;
   localparam int LimitWidth    = 4;
   localparam int HoldoffWidth  = 8;
   localparam int DivideWidth   = 4;
   localparam int CountWidth    = 5;
   localparam int CsrAddrWidth  = 5;
   localparam int CsrDataWidth  = 32;

   localparam logic [SampleWidth-1:0]  OptoThresholdReset = 12'h400;
   localparam logic [SampleWidth-1:0]  OutThresholdReset  = 12'hC00;
   localparam logic [LimitWidth-1:0]   CountLimitReset    = 4'd3;
   localparam logic [HoldoffWidth-1:0] HoldoffTicksReset  = 8'd40;
   localparam logic [DivideWidth-1:0]  TickDivideReset    = 4'd4;

   typedef enum logic [2:0] {
      REG_OPTO_THRESHOLD = 3'd0,
      REG_OUT_THRESHOLD  = 3'd1,
      REG_COUNT_LIMIT    = 3'd2,
      REG_HOLDOFF_TICKS  = 3'd3,
      REG_TICK_DIVIDE    = 3'd4
   } reg_index_type;

   typedef enum logic {
      MODE_TICK   = 1'b0,
      MODE_SAMPLE = 1'b1
   } mode_type;

   typedef struct packed {
      logic                   mode;
      logic [SampleWidth-1:0] sample;
   } req_type;

   typedef struct packed {
      logic drive_forward;
      logic opto_level;
      logic out_level;
      logic convert_start;
      logic convert_channel;
   } rsp_type;

endpackage

// File: hdl/dual_adc_debounce_motor_direction.sv
// Two-channel debouncer that sets a motor direction from one shared converter.
// req channel: each item is a raw timer tick (mode 0) or a conversion result
// (mode 1, sample valid). rsp channel: one item per req item with both
// debounced levels, drive_forward (levels equal), and whether this tick starts
// a conversion and on which channel (0 opto, 1 out).
// csr port: APB-style, registers at 0x00 opto_threshold, 0x04 out_threshold,
// 0x08 count_limit, 0x0C holdoff_ticks, 0x10 tick_divide; pready always high.
// The rsp item is registered and appears in the cycle after its req item is accepted.
// Throughput: one item per cycle while req_stall is low; all state is updated in the cycle of
// acceptance by a short compare/count path into the result register.
// When the receiver stalls, the result register holds its item and req_stall
// rises only while a held item is present, so a new item still enters in the
// cycle the held one is taken.
// Reset: counters, levels, hold-off, channel select and prescaler clear to
// zero; registers return to their default values; no rsp item is pending.
module dual_adc_debounce_motor_direction
   import dadmd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   logic [SampleWidth-1:0]  opto_threshold_ff, out_threshold_ff;
   logic [LimitWidth-1:0]   count_limit_ff;
   logic [HoldoffWidth-1:0] holdoff_ticks_ff;
   logic [DivideWidth-1:0]  tick_divide_ff;

   logic signed [CountWidth-1:0] opto_count_ff, opto_count_in;
   logic signed [CountWidth-1:0] out_count_ff, out_count_in;
   logic opto_high_ff, opto_high_in, out_high_ff, out_high_in;
   logic armed_rising_ff, armed_rising_in, armed_falling_ff, armed_falling_in;
   logic [HoldoffWidth-1:0] holdoff_left_ff, holdoff_left_in;
   logic opto_selected_ff, opto_selected_in, out_selected_ff, out_selected_in;
   logic [DivideWidth-1:0] prescale_count_ff, prescale_count_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                        accept, csr_write, start;
   logic [DivideWidth-1:0]      prescale_next;
   logic signed [CountWidth:0]  lim_pos, lim_neg, opto_wide, out_wide;
   reg_index_type               csr_index;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CsrAddrWidth-1:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      case (csr_index)
         REG_OPTO_THRESHOLD: prdata = CsrDataWidth'(opto_threshold_ff);
         REG_OUT_THRESHOLD:  prdata = CsrDataWidth'(out_threshold_ff);
         REG_COUNT_LIMIT:    prdata = CsrDataWidth'(count_limit_ff);
         REG_HOLDOFF_TICKS:  prdata = CsrDataWidth'(holdoff_ticks_ff);
         REG_TICK_DIVIDE:    prdata = CsrDataWidth'(tick_divide_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opto_threshold_ff <= OptoThresholdReset;
         out_threshold_ff  <= OutThresholdReset;
         count_limit_ff    <= CountLimitReset;
         holdoff_ticks_ff  <= HoldoffTicksReset;
         tick_divide_ff    <= TickDivideReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_OPTO_THRESHOLD: opto_threshold_ff <= pwdata[SampleWidth-1:0];
            REG_OUT_THRESHOLD:  out_threshold_ff  <= pwdata[SampleWidth-1:0];
            REG_COUNT_LIMIT:    count_limit_ff    <= pwdata[LimitWidth-1:0];
            REG_HOLDOFF_TICKS:  holdoff_ticks_ff  <= pwdata[HoldoffWidth-1:0];
            REG_TICK_DIVIDE:    tick_divide_ff    <= pwdata[DivideWidth-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign lim_pos       = $signed({2'b00, count_limit_ff});
   assign lim_neg       = -lim_pos;
   assign opto_wide     = {opto_count_ff[CountWidth-1], opto_count_ff};
   assign out_wide      = {out_count_ff[CountWidth-1], out_count_ff};
   assign prescale_next = prescale_count_ff + 1'b1;

   always_comb begin
      opto_count_in     = opto_count_ff;
      out_count_in      = out_count_ff;
      opto_high_in      = opto_high_ff;
      out_high_in       = out_high_ff;
      armed_rising_in   = armed_rising_ff;
      armed_falling_in  = armed_falling_ff;
      holdoff_left_in   = holdoff_left_ff;
      opto_selected_in  = opto_selected_ff;
      out_selected_in   = out_selected_ff;
      prescale_count_in = prescale_count_ff;
      start             = 1'b0;

      if (req_data.mode == MODE_TICK) begin
         prescale_count_in = prescale_next;
         if (prescale_next >= tick_divide_ff) begin
            prescale_count_in = '0;
            start             = 1'b1;
            if (holdoff_left_ff != '0) begin
               holdoff_left_in  = holdoff_left_ff - 1'b1;
               opto_selected_in = 1'b1;
               out_selected_in  = 1'b0;
            end else if (out_selected_ff) begin
               opto_selected_in = 1'b1;
               out_selected_in  = 1'b0;
            end else if (opto_selected_ff) begin
               opto_selected_in = 1'b0;
               out_selected_in  = 1'b1;
            end else begin
               opto_selected_in = 1'b1;
            end
         end
      end else if (opto_selected_ff) begin
         if (req_data.sample >= opto_threshold_ff) begin
            if (opto_wide < lim_pos) opto_count_in = opto_count_ff + 1'b1;
            else                     opto_high_in  = 1'b1;
         end else begin
            if (opto_wide > lim_neg) opto_count_in = opto_count_ff - 1'b1;
            else                     opto_high_in  = 1'b0;
         end
      end else if (out_selected_ff) begin
         if (req_data.sample >= out_threshold_ff) begin
            if (out_wide < lim_pos) begin
               out_count_in = out_count_ff + 1'b1;
            end else if (armed_rising_ff) begin
               out_high_in = 1'b1;
            end else begin
               holdoff_left_in  = holdoff_ticks_ff;
               armed_rising_in  = 1'b1;
               armed_falling_in = 1'b0;
            end
         end else begin
            if (out_wide > lim_neg) begin
               out_count_in = out_count_ff - 1'b1;
            end else if (armed_falling_ff) begin
               out_high_in = 1'b0;
            end else begin
               holdoff_left_in  = holdoff_ticks_ff;
               armed_falling_in = 1'b1;
               armed_rising_in  = 1'b0;
            end
         end
      end

      rsp_data_in.drive_forward   = opto_high_in == out_high_in;
      rsp_data_in.opto_level      = opto_high_in;
      rsp_data_in.out_level       = out_high_in;
      rsp_data_in.convert_start   = start;
      rsp_data_in.convert_channel = start & out_selected_in;

      rsp_valid_in = accept | req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opto_count_ff     <= '0;
         out_count_ff      <= '0;
         opto_high_ff      <= 1'b0;
         out_high_ff       <= 1'b0;
         armed_rising_ff   <= 1'b0;
         armed_falling_ff  <= 1'b0;
         holdoff_left_ff   <= '0;
         opto_selected_ff  <= 1'b0;
         out_selected_ff   <= 1'b0;
         prescale_count_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            opto_count_ff     <= opto_count_in;
            out_count_ff      <= out_count_in;
            opto_high_ff      <= opto_high_in;
            out_high_ff       <= out_high_in;
            armed_rising_ff   <= armed_rising_in;
            armed_falling_ff  <= armed_falling_in;
            holdoff_left_ff   <= holdoff_left_in;
            opto_selected_ff  <= opto_selected_in;
            out_selected_ff   <= out_selected_in;
            prescale_count_ff <= prescale_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
